[rtl/albe_pkg.sv]
// Package for the analog ladder button event block.
// Holds request codes, event codes, payload structs and the slot type.
package albe_pkg;

    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_EVENT   = 2'd1,
        REQ_PRESS   = 2'd2,
        REQ_RELEASE = 2'd3
    } t_req;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CLICK = 2'd1;
    localparam logic [1:0] EV_HOLD  = 2'd2;
    localparam logic [1:0] EV_LONG  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LVL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [LEVEL_W-1:0] adc_sample;
        logic [TIME_W-1:0]  now_ms;
        logic [ID_W-1:0]    button_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] instant_id;
        logic [1:0]      event_code;
        logic [ID_W-1:0] edge_id;
    } t_out_item;

    // classified request passed from front to back
    typedef struct packed {
        t_req              req;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] pressed_at;
        logic              hold_done;
        logic              long_done;
        logic [1:0]        pending;
    } t_slot;

    function automatic logic near_level(input logic [LEVEL_W-1:0] a,
                                        input logic [LEVEL_W-1:0] b,
                                        input logic [LEVEL_W-1:0] tol);
        logic [LEVEL_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d <= tol;
    endfunction

endpackage

[rtl/albe_front.sv]
// Front end: accepts requests and maps a tick's sample to an instant id.
// Depends on albe_pkg.
module albe_front
    import albe_pkg::*;
#(
    parameter int unsigned MAX_BUTTONS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_item           i_item,
    input  logic [2:0]         i_button_count,
    input  logic [79:0]        i_buttons,
    input  logic [LEVEL_W-1:0] i_idle_level,
    input  logic [LEVEL_W-1:0] i_tolerance,
    output logic               o_valid,
    output t_cmd               o_cmd
);

    logic [ID_W-1:0] n_id;
    logic            r_valid;
    t_cmd            r_cmd;

    always_comb begin
        logic found;
        logic [19:0] e;
        n_id  = '0;
        found = near_level(i_item.adc_sample, i_idle_level, i_tolerance);
        for (int k = 0; k < MAX_BUTTONS; k++) begin
            e = i_buttons[k*20 +: 20];
            if (!found && 32'(k) < 32'(i_button_count)
                && near_level(e[11:0], i_item.adc_sample, i_tolerance)) begin
                found = 1'b1;
                n_id  = e[19:12];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cmd   <= '0;
        end else begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_cmd.req    <= t_req'(i_item.req_type);
                r_cmd.now_ms <= i_item.now_ms;
                r_cmd.id     <= (t_req'(i_item.req_type) == REQ_TICK) ? n_id
                                                                      : i_item.button_id;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

[rtl/albe_back.sv]
// Back end: debounce, edge capture, slot table update and event take.
// Depends on albe_pkg.
module albe_back
    import albe_pkg::*;
#(
    parameter int unsigned MAX_BUTTONS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_cmd            i_cmd,
    input  logic [MS_W-1:0] i_debounce,
    input  logic [MS_W-1:0] i_hold,
    input  logic [MS_W-1:0] i_long,
    output logic            o_valid,
    output t_out_item       o_item
);

    localparam int unsigned IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

    logic [ID_W-1:0]   r_cand, r_acc, r_press, r_rel;
    logic [TIME_W-1:0] r_chg;
    t_slot             r_slot [MAX_BUTTONS];
    logic              r_valid;
    t_out_item         r_item;

    logic [ID_W-1:0]   n_cand, n_acc, n_press, n_rel;
    logic [TIME_W-1:0] n_chg;
    t_slot             n_slot [MAX_BUTTONS];
    t_out_item         n_item;

    always_comb begin
        logic [ID_W-1:0]   prev;
        logic              hit, free_hit;
        logic [IDX_W-1:0]  idx, fidx;
        logic [TIME_W-1:0] dur;
        n_cand  = r_cand;
        n_acc   = r_acc;
        n_press = r_press;
        n_rel   = r_rel;
        n_chg   = r_chg;
        for (int i = 0; i < MAX_BUTTONS; i++) n_slot[i] = r_slot[i];
        n_item  = '0;
        prev = '0; hit = 1'b0; free_hit = 1'b0; idx = '0; fidx = '0; dur = '0;
        unique case (i_cmd.req)
            REQ_TICK: begin
                n_item.instant_id = i_cmd.id;
                if (i_cmd.id != r_cand) begin
                    n_cand = i_cmd.id;
                    n_chg  = i_cmd.now_ms;
                end else begin
                    if (r_acc != r_cand
                        && (i_cmd.now_ms - r_chg) >= TIME_W'(i_debounce)) begin
                        prev  = r_acc;
                        n_acc = r_cand;
                        if (prev == '0) begin
                            n_press = r_cand;
                            for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
                                if (r_slot[i].id == r_cand) begin
                                    hit = 1'b1; idx = IDX_W'(i);
                                end
                                if (r_slot[i].id == '0) begin
                                    free_hit = 1'b1; fidx = IDX_W'(i);
                                end
                            end
                            if (!hit && free_hit) begin
                                hit = 1'b1; idx = fidx;
                            end
                            if (hit) begin
                                n_slot[idx].id         = r_cand;
                                n_slot[idx].pressed_at = i_cmd.now_ms;
                                n_slot[idx].hold_done  = 1'b0;
                                n_slot[idx].long_done  = 1'b0;
                                n_slot[idx].pending    = EV_NONE;
                            end
                        end else if (r_cand == '0) begin
                            n_rel = prev;
                            for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
                                if (r_slot[i].id == prev) begin
                                    hit = 1'b1; idx = IDX_W'(i);
                                end
                            end
                            if (hit && !r_slot[idx].hold_done && !r_slot[idx].long_done)
                                n_slot[idx].pending = EV_CLICK;
                        end
                    end
                    if (n_acc != '0) begin
                        hit = 1'b0;
                        for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
                            if (n_slot[i].id == n_acc) begin
                                hit = 1'b1; idx = IDX_W'(i);
                            end
                        end
                        if (hit) begin
                            dur = i_cmd.now_ms - n_slot[idx].pressed_at;
                            if (!n_slot[idx].long_done && dur >= TIME_W'(i_long)) begin
                                n_slot[idx].pending   = EV_LONG;
                                n_slot[idx].long_done = 1'b1;
                                n_slot[idx].hold_done = 1'b1;
                            end else if (!n_slot[idx].hold_done
                                         && dur >= TIME_W'(i_hold)) begin
                                n_slot[idx].pending   = EV_HOLD;
                                n_slot[idx].hold_done = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_EVENT: begin
                if (i_cmd.id != '0) begin
                    for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
                        if (r_slot[i].id == i_cmd.id) begin
                            hit = 1'b1; idx = IDX_W'(i);
                        end
                    end
                    if (hit) begin
                        n_item.event_code   = r_slot[idx].pending;
                        n_slot[idx].pending = EV_NONE;
                        if (r_slot[idx].pending != EV_NONE && r_acc == '0)
                            n_slot[idx].id = '0;
                    end
                end
            end
            REQ_PRESS: begin
                n_item.edge_id = r_press;
                n_press = '0;
            end
            REQ_RELEASE: begin
                n_item.edge_id = r_rel;
                n_rel = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand  <= '0;
            r_acc   <= '0;
            r_press <= '0;
            r_rel   <= '0;
            r_chg   <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < MAX_BUTTONS; i++) r_slot[i] <= '0;
        end else begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_cand  <= n_cand;
                r_acc   <= n_acc;
                r_press <= n_press;
                r_rel   <= n_rel;
                r_chg   <= n_chg;
                for (int i = 0; i < MAX_BUTTONS; i++) r_slot[i] <= n_slot[i];
            end
        end
        if (i_valid) r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_slot_id_zero_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot[0].id == '0) |-> (r_slot[0].pending == EV_NONE))
        else $error("slot state inconsistent");
    a_long_implies_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot[0].long_done |-> r_slot[0].hold_done)
        else $error("long hold without hold");
    a_out_follows_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> r_valid)
        else $error("lost result");

endmodule

[rtl/analog_ladder_button_events.sv]
// Top level of the analog ladder button event block.
// Depends on albe_pkg, albe_front and albe_back.
// Each request passes the front end, where the sample is matched against the ladder
// levels, and then the back end, where the debounce, slot table and edge registers are
// updated; both register their results. busy stays high while the request is in flight;
// the result appears on o_result for one cycle with o_done and cannot be stalled.
// Configuration writes are held off while a request is in flight or offered.
module analog_ladder_button_events
    import albe_pkg::*;
#(
    parameter int unsigned MAX_BUTTONS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_done,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [2:0]         r_count;
    logic [79:0]        r_buttons;
    logic [LEVEL_W-1:0] r_idle, r_tol;
    logic [MS_W-1:0]    r_deb, r_hold, r_long;
    logic [1:0]         r_busy;
    logic [2:0]         n_count_c;
    logic               accept, f_valid;
    t_cmd               f_cmd;

    assign accept      = start && !busy;
    assign busy        = r_busy != 2'd0;
    assign o_cfg_ready = !busy && !start;
    assign n_count_c   = (32'(r_count) > MAX_BUTTONS) ? 3'(MAX_BUTTONS) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_buttons <= '0;
            r_idle    <= 12'd4095;
            r_tol     <= 12'd50;
            r_deb     <= 16'd50;
            r_hold    <= 16'd500;
            r_long    <= 16'd2000;
            r_busy    <= '0;
        end else begin
            r_busy <= accept ? 2'd2 : (busy ? r_busy - 2'd1 : 2'd0);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_COUNT:    r_count <= i_cfg_data[2:0];
                    CFG_PAIR_LO:  r_buttons[39:0] <= i_cfg_data;
                    CFG_PAIR_HI:  r_buttons[79:40] <= i_cfg_data;
                    CFG_IDLE_LVL: r_idle <= i_cfg_data[11:0];
                    CFG_TOL:      r_tol <= i_cfg_data[11:0];
                    CFG_DEBOUNCE: r_deb <= i_cfg_data[15:0];
                    CFG_HOLD:     r_hold <= i_cfg_data[15:0];
                    CFG_LONG:     r_long <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    albe_front #(.MAX_BUTTONS(MAX_BUTTONS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_item(i_item),
        .i_button_count(n_count_c), .i_buttons(r_buttons), .i_idle_level(r_idle),
        .i_tolerance(r_tol), .o_valid(f_valid), .o_cmd(f_cmd)
    );

    albe_back #(.MAX_BUTTONS(MAX_BUTTONS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_cmd(f_cmd),
        .i_debounce(r_deb), .i_hold(r_hold), .i_long(r_long),
        .o_valid(o_done), .o_item(o_result)
    );

endmodule

[bench/analog_ladder_button_events_checker.sv]
// Checker for the analog ladder button event block: models debounce, slot table
// and edge registers, and compares every strobed result. Depends on albe_pkg.
`timescale 1ns / 100ps
module analog_ladder_button_events_checker
    import albe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  t_in_item              i_item,
    input  logic                  o_done,
    input  t_out_item             o_result,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    localparam int unsigned NSLOT = 4;

    logic [2:0]          m_count;
    logic [39:0]         m_pair_lo, m_pair_hi;
    logic [LEVEL_W-1:0]  m_idle, m_tol;
    logic [MS_W-1:0]     m_debounce, m_hold, m_long;
    logic [ID_W-1:0]     m_cand, m_acc, m_prev, m_press, m_release;
    logic [TIME_W-1:0]   m_change;
    t_slot               m_slots[NSLOT];
    t_out_item           expected_q[$];

    assign o_pending = expected_q.size();

    function automatic logic close_to(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
        logic [LEVEL_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d <= m_tol;
    endfunction

    function automatic logic [ID_W-1:0] ladder_id(logic [LEVEL_W-1:0] s);
        int n;
        logic [19:0] e;
        n = (m_count > NSLOT) ? NSLOT : m_count;
        if (close_to(s, m_idle)) return '0;
        for (int k = 0; k < n; k++) begin
            e = (k < 2) ? m_pair_lo[(k%2)*20 +: 20] : m_pair_hi[(k%2)*20 +: 20];
            if (close_to(e[11:0], s)) return e[19:12];
        end
        return '0;
    endfunction

    function automatic int slot_of(logic [ID_W-1:0] id);
        for (int i = 0; i < NSLOT; i++)
            if (m_slots[i].id == id) return i;
        return -1;
    endfunction

    function automatic void arm(int i, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
        m_slots[i] = '{id: id, pressed_at: t, hold_done: 1'b0, long_done: 1'b0,
                       pending: EV_NONE};
    endfunction

    function automatic void advance_tick(logic [ID_W-1:0] inst, logic [TIME_W-1:0] t);
        int idx;
        logic [TIME_W-1:0] dur;
        if (inst != m_cand) begin
            m_cand = inst;
            m_change = t;
            return;
        end
        if (m_acc != m_cand && (t - m_change) >= m_debounce) begin
            m_prev = m_acc;
            m_acc = m_cand;
            if (m_prev == 0 && m_acc != 0) begin
                m_press = m_acc;
                idx = slot_of(m_acc);
                if (idx < 0) begin
                    idx = slot_of('0);
                    if (idx >= 0) arm(idx, m_acc, t);
                end else begin
                    arm(idx, m_acc, t);
                end
            end else if (m_prev != 0 && m_acc == 0) begin
                m_release = m_prev;
                idx = slot_of(m_prev);
                if (idx >= 0 && !m_slots[idx].hold_done && !m_slots[idx].long_done)
                    m_slots[idx].pending = EV_CLICK;
            end
        end
        if (m_acc != 0) begin
            idx = slot_of(m_acc);
            if (idx >= 0) begin
                dur = t - m_slots[idx].pressed_at;
                if (!m_slots[idx].long_done && dur >= m_long) begin
                    m_slots[idx].pending = EV_LONG;
                    m_slots[idx].long_done = 1'b1;
                    m_slots[idx].hold_done = 1'b1;
                end else if (!m_slots[idx].hold_done && dur >= m_hold) begin
                    m_slots[idx].pending = EV_HOLD;
                    m_slots[idx].hold_done = 1'b1;
                end
            end
        end
    endfunction

    function automatic t_out_item serve(t_in_item it);
        t_out_item r;
        int idx;
        r = '0;
        case (t_req'(it.req_type))
            REQ_TICK: begin
                r.instant_id = ladder_id(it.adc_sample);
                advance_tick(r.instant_id, it.now_ms);
            end
            REQ_EVENT: begin
                idx = (it.button_id == 0) ? -1 : slot_of(it.button_id);
                if (idx >= 0) begin
                    r.event_code = m_slots[idx].pending;
                    m_slots[idx].pending = EV_NONE;
                    if (r.event_code != EV_NONE && m_acc == 0) m_slots[idx].id = '0;
                end
            end
            REQ_PRESS: begin
                r.edge_id = m_press;
                m_press = '0;
            end
            default: begin
                r.edge_id = m_release;
                m_release = '0;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            m_count <= '0; m_pair_lo <= '0; m_pair_hi <= '0;
            m_idle <= 12'd4095; m_tol <= 12'd50;
            m_debounce <= 16'd50; m_hold <= 16'd500; m_long <= 16'd2000;
            m_cand <= '0; m_acc <= '0; m_prev <= '0; m_change <= '0;
            m_press <= '0; m_release <= '0;
            for (int i = 0; i < NSLOT; i++) m_slots[i] <= '0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.instant_id != o_result.instant_id ||
                        want.event_code != o_result.event_code ||
                        want.edge_id != o_result.edge_id) begin
                        $display("%0t: mismatch expected id=%0d ev=%0d edge=%0d",
                                 $time, want.instant_id, want.event_code, want.edge_id,
                                 " actual id=%0d ev=%0d edge=%0d",
                                 o_result.instant_id, o_result.event_code,
                                 o_result.edge_id);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COUNT:    m_count    = i_cfg_data[2:0];
                    CFG_PAIR_LO:  m_pair_lo  = i_cfg_data;
                    CFG_PAIR_HI:  m_pair_hi  = i_cfg_data;
                    CFG_IDLE_LVL: m_idle     = i_cfg_data[11:0];
                    CFG_TOL:      m_tol      = i_cfg_data[11:0];
                    CFG_DEBOUNCE: m_debounce = i_cfg_data[15:0];
                    CFG_HOLD:     m_hold     = i_cfg_data[15:0];
                    default:      m_long     = i_cfg_data[15:0];
                endcase
            end
            if (start && !busy) expected_q.push_back(serve(i_item));
        end
    end
endmodule

[bench/analog_ladder_button_events_tb.sv]
// Top of the analog ladder button event bench: clock, reset, configuration
// phases and request stimulus. Depends on albe_pkg, the block and its checker.
`timescale 1ns / 100ps
module analog_ladder_button_events_tb;
    import albe_pkg::*;

    localparam longint LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_item              i_item = '0;
    logic                  o_done;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count, pending;
    longint                cycle_count = 0;
    int                    gap_pct = 0;
    logic [TIME_W-1:0]     clock_ms;
    logic [LEVEL_W-1:0]    levels[4];
    logic [ID_W-1:0]       ids[4];

    always #4 i_clk = ~i_clk;

    analog_ladder_button_events uut (.*);
    analog_ladder_button_events_checker chk (.*, .o_fail_count(fail_count),
                                             .o_pending(pending));

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid is left high for a following write and dropped by the caller
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // start is left high for a following transaction; drop it in the gap or drain
    task automatic send(t_req r, logic [LEVEL_W-1:0] s, logic [TIME_W-1:0] t,
                        logic [ID_W-1:0] id);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= '{req_type: r, adc_sample: s, now_ms: t, button_id: id};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Ladder with distinct levels; small times in most phases so holds occur often
    task automatic configure(int phase);
        logic [2:0] cnt;
        for (int k = 0; k < 4; k++) begin
            levels[k] = 12'(300 + k * 800 + $urandom_range(40));
            ids[k] = (phase == 0 && k == 3) ? 8'hFF : 8'(k * 37 + 1 + phase);
        end
        cnt = (phase == 1) ? 3'd7 : 3'($urandom_range(2, 4));
        write_reg(CFG_COUNT, 40'(cnt));
        write_reg(CFG_PAIR_LO, {ids[1], levels[1], ids[0], levels[0]});
        write_reg(CFG_PAIR_HI, {ids[3], levels[3], ids[2], levels[2]});
        write_reg(CFG_IDLE_LVL, (phase == 2) ? 40'd0 : 40'd4095);
        write_reg(CFG_TOL, (phase == 3) ? 40'd0 : 40'($urandom_range(5, 60)));
        write_reg(CFG_DEBOUNCE, (phase == 1) ? 40'd0 : 40'($urandom_range(1, 20)));
        write_reg(CFG_HOLD, (phase == 3) ? 40'hFFFF : 40'($urandom_range(10, 60)));
        write_reg(CFG_LONG, (phase == 3) ? 40'hFFFF : 40'($urandom_range(40, 150)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic press_sequence(int k);
        int dwell;
        dwell = $urandom_range(1, 40);
        for (int j = 0; j < dwell; j++) begin
            clock_ms += $urandom_range(0, 12);
            send(REQ_TICK, levels[k], clock_ms, '0);
        end
        if ($urandom_range(1)) send(REQ_EVENT, '0, '0, ids[k]);
        for (int j = 0; j < dwell / 2 + 2; j++) begin
            clock_ms += $urandom_range(0, 15);
            send(REQ_TICK, 12'd4095, clock_ms, '0);
        end
        send(REQ_PRESS, '0, '0, '0);
        send(REQ_RELEASE, '0, '0, '0);
        send(REQ_EVENT, '0, '0, ids[k]);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes of fields, every request, id zero and unknown ids
        send(REQ_EVENT, '0, '0, '0);
        send(REQ_EVENT, '0, '0, 8'hFF);
        send(REQ_PRESS, 12'hFFF, '1, '1);
        send(REQ_RELEASE, 12'hFFF, '1, '1);
        send(REQ_TICK, 12'd0, '1, '0);
        send(REQ_TICK, 12'd0, 32'd5, 8'hFF);
        send(REQ_TICK, 12'hFFF, 32'hFFFF_FFF0, '0);
        drain();
        configure(0);
        clock_ms = 32'hFFFF_FF00;
        send(REQ_TICK, levels[3], clock_ms, '0);
        send(REQ_TICK, levels[3], clock_ms + 300, '0);
        send(REQ_TICK, levels[0], clock_ms + 310, '0);
        send(REQ_TICK, levels[0], clock_ms + 400, '0);
        send(REQ_TICK, 12'hFFF, clock_ms + 410, '0);
        send(REQ_TICK, 12'hFFF, clock_ms + 600, '0);
        send(REQ_PRESS, '0, '0, '0);
        send(REQ_RELEASE, '0, '0, '0);
        for (int k = 0; k < 4; k++) send(REQ_EVENT, '0, '0, ids[k]);
        clock_ms += 700;
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            if (phase > 0) configure(phase);
            gap_pct = (phase == 1 || phase == 4) ? 72 : (phase == 3 ? 29 : 0);
            for (int n = 0; n < 12; n++) begin
                if ($urandom_range(9) < 8) press_sequence($urandom_range(3));
                else send(t_req'($urandom_range(3)), 12'($urandom),
                          $urandom, 8'($urandom));
            end
        end
        drain();
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
